/* sv/mfd_pkg.sv */
// package for the maze flood distance map
// opcodes, states, constants and the cell control type; no dependencies
`timescale 1ns / 1ps

package mfd_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FLOOD = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLOOD,
      ST_RESP
   } state_type;

   localparam logic [7:0] UNREACHED = 8'd128;
   localparam logic [3:0] GOAL_RESET = 4'd7;
   localparam int CFG_GOAL_ROW = 0;
   localparam int CFG_GOAL_COL = 1;

   // control broadcast to every cell
   typedef struct packed {
      logic clear;
      logic seed;
      logic grow;
      logic write;
   } cell_ctrl_type;

endpackage

/* sv/mfd_cell.sv */
// one maze cell: walls, visited flag and distance; the flood wave enters it once per flood
// depends on mfd_pkg
`timescale 1ns / 1ps

module mfd_cell
   import mfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          sel,
   input  logic [3:0]    wall_bits,
   input  logic          is_goal,
   input  logic [3:0]    nbr_push,
   input  logic [7:0]    layer_dist,
   output logic [3:0]    walls,
   output logic          visited,
   output logic [7:0]    cell_dist,
   output logic          fresh
);

   logic [3:0] walls_ff;
   logic       visited_ff, fresh_ff;
   logic [7:0] dist_ff;
   logic       enter;

   assign enter = ctrl.grow && !visited_ff && (nbr_push != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff   <= '0;
         visited_ff <= 1'b0;
         fresh_ff   <= 1'b0;
         dist_ff    <= UNREACHED;
      end else begin
         if (ctrl.write && sel) begin
            walls_ff <= wall_bits;
         end
         if (ctrl.clear) begin
            visited_ff <= 1'b0;
            fresh_ff   <= 1'b0;
            dist_ff    <= UNREACHED;
         end else if (ctrl.seed) begin
            visited_ff <= is_goal;
            fresh_ff   <= is_goal;
            dist_ff    <= is_goal ? 8'd0 : UNREACHED;
         end else if (ctrl.grow) begin
            fresh_ff <= enter;
            if (enter) begin
               visited_ff <= 1'b1;
               dist_ff    <= layer_dist;
            end
         end
      end
   end

   assign walls     = walls_ff;
   assign visited   = visited_ff;
   assign cell_dist = dist_ff;
   assign fresh     = fresh_ff;

endmodule

/* sv/maze_flood_distance_map_top.sv */
// top level of the maze flood distance map: grid of cells and flood sequencer
// depends on mfd_pkg and mfd_cell
//
//   channel | direction | ports
//   req     | in        | req_valid/ready, opcode, cell_row, cell_col, wall_bits
//   rsp     | out       | rsp_valid/ready, distance, reached, reached_count
//   csr     | in        | csr_valid/ready, csr_index, csr_data
//
// a write or read is registered, then done in the response state; a flood seeds the goal,
// grows the wave layer by layer, then counts reached cells in a sweep of one cell per cycle
// reset: goal 7,7, no walls, all cells unreached
// a result waits in the output register; the next request is taken once it is gone
`timescale 1ns / 1ps

module maze_flood_distance_map_top
   import mfd_pkg::*;
#(
   parameter int GRID_SIDE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_cell_row,
   input  logic [3:0] req_cell_col,
   input  logic [3:0] req_wall_bits,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_distance,
   output logic       rsp_reached,
   output logic [8:0] rsp_reached_count,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [3:0] csr_data
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CW = $clog2(CELLS);
   localparam int SW = $clog2(GRID_SIDE);

   state_type   state_ff, state_in;
   logic [3:0]  goal_row_ff, goal_col_ff;
   logic [7:0]  layer_ff, layer_in;
   logic [CW:0] sweep_ff, sweep_in;
   logic [8:0]  count_ff, count_in;
   logic        sweeping_ff, sweeping_in;
   logic [1:0]  op_ff;
   logic [3:0]  row_ff, col_ff, wb_ff;
   logic        rv_ff, rv_in;
   logic [7:0]  rd_ff, rd_in;
   logic        rr_ff, rr_in;
   logic [8:0]  rc_ff, rc_in;
   cell_ctrl_type ctrl;

   logic [CELLS-1:0] c_vis, c_fresh;
   logic [3:0]       c_walls [CELLS];
   logic [7:0]       c_dist  [CELLS];
   logic             any_fresh;
   logic             in_grid, goal_in;

   assign in_grid = ({4'd0, row_ff} < 8'(GRID_SIDE)) && ({4'd0, col_ff} < 8'(GRID_SIDE));
   assign goal_in = ({4'd0, goal_row_ff} < 8'(GRID_SIDE))
                    && ({4'd0, goal_col_ff} < 8'(GRID_SIDE));
   assign any_fresh = |c_fresh;

   for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
      for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
         localparam int I = r * GRID_SIDE + c;
         logic [3:0] push;
         logic sel, goal;
         // a neighbour pushes if freshly entered and its own wall toward us is clear
         if (r > 0) begin : g_n
            assign push[0] = c_fresh[I-GRID_SIDE] && !c_walls[I-GRID_SIDE][2];
         end else begin : g_nn
            assign push[0] = 1'b0;
         end
         if (c < GRID_SIDE-1) begin : g_e
            assign push[1] = c_fresh[I+1] && !c_walls[I+1][3];
         end else begin : g_ne
            assign push[1] = 1'b0;
         end
         if (r < GRID_SIDE-1) begin : g_s
            assign push[2] = c_fresh[I+GRID_SIDE] && !c_walls[I+GRID_SIDE][0];
         end else begin : g_ns
            assign push[2] = 1'b0;
         end
         if (c > 0) begin : g_w
            assign push[3] = c_fresh[I-1] && !c_walls[I-1][1];
         end else begin : g_nw
            assign push[3] = 1'b0;
         end
         assign sel  = in_grid && (SW'(row_ff) == SW'(r)) && (SW'(col_ff) == SW'(c));
         assign goal = goal_in && (SW'(goal_row_ff) == SW'(r))
                       && (SW'(goal_col_ff) == SW'(c));
         mfd_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(ctrl), .sel(sel),
            .wall_bits(wb_ff), .is_goal(goal), .nbr_push(push),
            .layer_dist(layer_ff), .walls(c_walls[I]), .visited(c_vis[I]),
            .cell_dist(c_dist[I]), .fresh(c_fresh[I])
         );
      end
   end

   logic [CW-1:0] rd_idx;
   assign rd_idx = CW'(int'(row_ff) * GRID_SIDE + int'(col_ff));

   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         goal_row_ff <= GOAL_RESET;
         goal_col_ff <= GOAL_RESET;
         layer_ff    <= '0;
         sweep_ff    <= '0;
         count_ff    <= '0;
         sweeping_ff <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         layer_ff    <= layer_in;
         sweep_ff    <= sweep_in;
         count_ff    <= count_in;
         sweeping_ff <= sweeping_in;
         rv_ff       <= rv_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == 1'(CFG_GOAL_ROW)) goal_row_ff <= csr_data;
            else goal_col_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      rr_ff <= rr_in;
      rc_ff <= rc_in;
      if (req_valid && req_ready) begin
         op_ff  <= req_opcode;
         row_ff <= req_cell_row;
         col_ff <= req_cell_col;
         wb_ff  <= req_wall_bits;
      end
   end

   always_comb begin
      state_in    = state_ff;
      layer_in    = layer_ff;
      sweep_in    = sweep_ff;
      count_in    = count_ff;
      sweeping_in = sweeping_ff;
      rv_in       = rv_ff && !rsp_ready;
      rd_in       = rd_ff;
      rr_in       = rr_ff;
      rc_in       = rc_ff;
      ctrl        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
            rd_in = '0;
            rr_in = 1'b0;
            rc_in = '0;
            case (opcode_type'(op_ff))
               OP_WRITE: begin
                  ctrl.write = 1'b1;
                  rv_in = 1'b1;
               end
               OP_READ: begin
                  rd_in = in_grid ? c_dist[rd_idx] : UNREACHED;
                  rr_in = in_grid && c_vis[rd_idx];
                  rv_in = 1'b1;
               end
               OP_FLOOD: begin
                  ctrl.seed   = 1'b1;
                  layer_in    = 8'd1;
                  sweeping_in = 1'b0;
                  state_in    = ST_FLOOD;
               end
               default: rv_in = 1'b1;
            endcase
         end
         ST_FLOOD: begin
            if (!sweeping_ff) begin
               if (any_fresh) begin
                  ctrl.grow = 1'b1;
                  layer_in  = (layer_ff == 8'd255) ? 8'd255 : layer_ff + 8'd1;
               end else begin
                  sweeping_in = 1'b1;
                  sweep_in    = '0;
                  count_in    = '0;
               end
            end else if (sweep_ff == (CW+1)'(CELLS)) begin
               rc_in    = count_ff;
               rd_in    = '0;
               rr_in    = 1'b0;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
               if (c_vis[sweep_ff[CW-1:0]] && count_ff != 9'd511) count_in = count_ff + 9'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = rv_ff;
   assign rsp_distance      = rd_ff;
   assign rsp_reached       = rr_ff;
   assign rsp_reached_count = rc_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_grow_fresh: assert property (@(posedge clock) disable iff (reset)
      ctrl.grow |-> any_fresh) else $error("grow without wavefront");

endmodule

/* verif/maze_flood_distance_map_top_tb.sv */
// testbench for maze_flood_distance_map_top: wall writes, floods and distance reads
// checked against a flood predictor in a small scoreboard class; depends on mfd_pkg
`timescale 1ns / 1ps

module maze_flood_distance_map_top_tb;
   import mfd_pkg::*;

   typedef struct packed {
      logic [7:0] distance;
      logic       reached;
      logic [8:0] reached_count;
   } flood_result_type;

   class flood_scoreboard;
      logic [3:0] walls [256];
      logic [7:0] dist_map [256];
      logic       seen [256];
      logic [3:0] goal_row;
      logic [3:0] goal_col;
      flood_result_type pending_results [$];
      int mismatches;

      function new();
         for (int i = 0; i < 256; i++) begin
            walls[i] = 4'd0;
            dist_map[i] = UNREACHED;
            seen[i] = 1'b0;
         end
         goal_row = GOAL_RESET;
         goal_col = GOAL_RESET;
         mismatches = 0;
      endfunction

      function void set_goal(logic idx, logic [3:0] value);
         if (idx == 1'(CFG_GOAL_ROW)) goal_row = value;
         else goal_col = value;
      endfunction

      function void enter(int idx, logic [7:0] d, ref int frontier [256], ref int tail);
         if (seen[idx]) return;
         seen[idx] = 1'b1;
         dist_map[idx] = d;
         frontier[tail] = idx;
         tail++;
      endfunction

      function int flood();
         int frontier [256];
         int head;
         int tail;
         int idx;
         logic [7:0] nd;
         head = 0;
         tail = 0;
         for (int i = 0; i < 256; i++) begin
            dist_map[i] = UNREACHED;
            seen[i] = 1'b0;
         end
         enter(goal_row * 16 + goal_col, 8'd0, frontier, tail);
         while (head < tail) begin
            idx = frontier[head];
            head++;
            nd = (dist_map[idx] == 8'd255) ? 8'd255 : dist_map[idx] + 8'd1;
            if (idx % 16 > 0 && !walls[idx][3]) enter(idx - 1, nd, frontier, tail);
            if (idx % 16 < 15 && !walls[idx][1]) enter(idx + 1, nd, frontier, tail);
            if (idx / 16 > 0 && !walls[idx][0]) enter(idx - 16, nd, frontier, tail);
            if (idx / 16 < 15 && !walls[idx][2]) enter(idx + 16, nd, frontier, tail);
         end
         return tail;
      endfunction

      function void note_request(opcode_type op, logic [3:0] row, logic [3:0] col,
                                 logic [3:0] wb);
         flood_result_type r;
         r = '0;
         case (op)
            OP_WRITE: walls[row * 16 + col] = wb;
            OP_FLOOD: r.reached_count = 9'(flood());
            OP_READ: begin
               r.distance = dist_map[row * 16 + col];
               r.reached = seen[row * 16 + col];
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(flood_result_type got);
         flood_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = '0;
   logic [3:0] req_cell_row = '0;
   logic [3:0] req_cell_col = '0;
   logic [3:0] req_wall_bits = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_distance;
   logic       rsp_reached;
   logic [8:0] rsp_reached_count;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [3:0] csr_data = '0;

   flood_scoreboard board;
   bit quiet_phase = 1'b0;
   bit hold_rsp = 1'b0;

   maze_flood_distance_map_top uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_distance, rsp_reached, rsp_reached_count});
   end

   // valid stays high into the next transfer unless an idle burst or a drain follows
   task automatic send_request(opcode_type op, logic [3:0] row, logic [3:0] col,
                               logic [3:0] wb, bit may_idle);
      if (may_idle && !quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_cell_row <= row;
      req_cell_col <= col;
      req_wall_bits <= wb;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, row, col, wb);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_goal(logic idx, logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_goal(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 11)
         send_request(OP_WRITE, 4'($urandom), 4'($urandom),
                      $urandom_range(0, 5) == 0 ? 4'd0 : 4'($urandom), 1);
      else if (pick < 18)
         send_request(OP_READ, 4'($urandom), 4'($urandom), 4'($urandom), 1);
      else if (pick == 18)
         send_request(OP_FLOOD, 4'($urandom), 4'($urandom), 4'($urandom), 1);
      else
         send_request(OP_NONE, 4'($urandom), 4'($urandom), 4'($urandom), 1);
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reads before any flood, corners, open-field flood
      send_request(OP_READ, 4'd7, 4'd7, 4'd0, 0);
      send_request(OP_READ, 4'd15, 4'd15, 4'd15, 0);
      send_request(OP_NONE, 4'd15, 4'd15, 4'd15, 0);
      send_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd15, 4'd15, 4'd0, 0);
      send_request(OP_READ, 4'd7, 4'd7, 4'd0, 0);
      // wall off a corner, edge walls ignored at the boundary
      send_request(OP_WRITE, 4'd0, 4'd1, 4'b1000, 0);
      send_request(OP_WRITE, 4'd1, 4'd0, 4'b0001, 0);
      send_request(OP_WRITE, 4'd0, 4'd0, 4'b0000, 0);
      send_request(OP_WRITE, 4'd15, 4'd15, 4'b1111, 0);
      send_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd15, 4'd15, 4'd0, 0);
      drain_results();

      write_goal(1'(CFG_GOAL_ROW), 4'd0);
      write_goal(1'(CFG_GOAL_COL), 4'd0);
      send_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd15, 4'd14, 4'd0, 0);
      drain_results();
      write_goal(1'(CFG_GOAL_ROW), 4'd15);
      write_goal(1'(CFG_GOAL_COL), 4'd15);
      send_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, 0);
      send_request(OP_READ, 4'd0, 4'd1, 4'd0, 0);
      drain_results();

      // random phases with differing goals
      for (int phase = 0; phase < 6; phase++) begin
         write_goal(1'(CFG_GOAL_ROW), 4'($urandom));
         write_goal(1'(CFG_GOAL_COL), 4'($urandom));
         if (phase == 2) hold_rsp = 1'b1;
         if (phase == 5) quiet_phase = 1'b1;
         for (int n = 0; n < 72; n++) random_request();
         send_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, 1);
         for (int n = 0; n < 6; n++)
            send_request(OP_READ, 4'($urandom), 4'($urandom), 4'd0, 1);
         drain_results();
      end

      drain_results();
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
